// File: design/autorange_light_averager_top_defines.svh
// Assertion macros shared by the auto-ranging light averager modules.
`ifndef AUTORANGE_LIGHT_AVERAGER_TOP_DEFINES_SVH
`define AUTORANGE_LIGHT_AVERAGER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle property, checked at every rising edge outside reset.
`define ARL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle property: the consequent must hold after the antecedent.
`define ARL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARL_ASSERT(label, clk, rst_n, prop, msg)
`define ARL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/arl_pkg.sv
// Types, constants and helper functions of the auto-ranging light averager.
`timescale 1ns / 1ps

package arl_pkg;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned THRESH_W   = 8;
    localparam int unsigned FACTOR_W   = 10;
    localparam int unsigned BASE_W     = 8;
    localparam int unsigned LEVEL_W    = 2;
    localparam int unsigned PORT_W     = 8;
    localparam int unsigned SUM_OUT_W  = 24;
    localparam int unsigned PROD_W     = SAMPLE_W + FACTOR_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hFF;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MID    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_LEVEL0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_LEVEL1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_LEVEL2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_BASE_BITS = 3'd5;

    localparam logic [THRESH_W-1:0] RESET_LOW_THRESHOLD  = 8'd15;
    localparam logic [THRESH_W-1:0] RESET_HIGH_THRESHOLD = 8'd200;
    localparam logic [FACTOR_W-1:0] RESET_FACTOR_LEVEL0  = 10'd1;
    localparam logic [FACTOR_W-1:0] RESET_FACTOR_LEVEL1  = 10'd33;
    localparam logic [FACTOR_W-1:0] RESET_FACTOR_LEVEL2  = 10'd1000;
    localparam logic [BASE_W-1:0]   RESET_PORT_BASE_BITS = 8'd0;

    // Port drive patterns for each gain level.
    localparam logic [PORT_W-1:0] DRIVE_LEVEL0 = 8'b0110_0000;
    localparam logic [PORT_W-1:0] DRIVE_LEVEL1 = 8'b1010_0000;
    localparam logic [PORT_W-1:0] DRIVE_LEVEL2 = 8'b1100_0000;

    typedef struct packed {
        logic [THRESH_W-1:0] low_threshold;
        logic [THRESH_W-1:0] high_threshold;
        logic [FACTOR_W-1:0] factor_level0;
        logic [FACTOR_W-1:0] factor_level1;
        logic [FACTOR_W-1:0] factor_level2;
        logic [BASE_W-1:0]   port_base_bits;
    } cfg_t;

    typedef struct packed {
        logic [SUM_OUT_W-1:0] brightness_sum;
        logic [LEVEL_W-1:0]   gain_level;
        logic [PORT_W-1:0]    port_mode;
    } result_t;

    function automatic logic [PORT_W-1:0] drive_code(input logic [LEVEL_W-1:0] level);
        logic [PORT_W-1:0] code;
        case (level)
            LEVEL_MIN: code = DRIVE_LEVEL0;
            LEVEL_MID: code = DRIVE_LEVEL1;
            default:   code = DRIVE_LEVEL2;
        endcase
        return code;
    endfunction

endpackage

// File: design/arl_if.sv
// Handshake channel interfaces for samples, results and configuration writes.
`timescale 1ns / 1ps

interface arl_in_if;
    logic                          valid;
    logic                          ready;
    logic [arl_pkg::SAMPLE_W-1:0]  adc_raw;

    modport source (output valid, output adc_raw, input ready);
    modport sink (input valid, input adc_raw, output ready);
endinterface

interface arl_out_if;
    logic                          valid;
    logic                          ready;
    logic [arl_pkg::SUM_OUT_W-1:0] brightness_sum;
    logic [arl_pkg::LEVEL_W-1:0]   gain_level;
    logic [arl_pkg::PORT_W-1:0]    port_mode;

    modport source (output valid, output brightness_sum, output gain_level,
                    output port_mode, input ready);
    modport sink (input valid, input brightness_sum, input gain_level,
                  input port_mode, output ready);
endinterface

interface arl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [arl_pkg::CFG_IDX_W-1:0]  index;
    logic [arl_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/arl_cfg.sv
// Configuration register file of the light averager.
`timescale 1ns / 1ps

module arl_cfg
(
    input  logic          clk,
    input  logic          rst_n,
    arl_cfg_if.sink       cfg,
    output arl_pkg::cfg_t regs
);

    arl_pkg::cfg_t regs_reg;
    arl_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;

    // Writes to indexes past the register list leave everything unchanged.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                arl_pkg::REG_LOW_THRESHOLD:
                    regs_next.low_threshold = cfg.data[arl_pkg::THRESH_W-1:0];
                arl_pkg::REG_HIGH_THRESHOLD:
                    regs_next.high_threshold = cfg.data[arl_pkg::THRESH_W-1:0];
                arl_pkg::REG_FACTOR_LEVEL0:
                    regs_next.factor_level0 = cfg.data[arl_pkg::FACTOR_W-1:0];
                arl_pkg::REG_FACTOR_LEVEL1:
                    regs_next.factor_level1 = cfg.data[arl_pkg::FACTOR_W-1:0];
                arl_pkg::REG_FACTOR_LEVEL2:
                    regs_next.factor_level2 = cfg.data[arl_pkg::FACTOR_W-1:0];
                arl_pkg::REG_PORT_BASE_BITS:
                    regs_next.port_base_bits = cfg.data[arl_pkg::BASE_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.low_threshold  <= arl_pkg::RESET_LOW_THRESHOLD;
            regs_reg.high_threshold <= arl_pkg::RESET_HIGH_THRESHOLD;
            regs_reg.factor_level0  <= arl_pkg::RESET_FACTOR_LEVEL0;
            regs_reg.factor_level1  <= arl_pkg::RESET_FACTOR_LEVEL1;
            regs_reg.factor_level2  <= arl_pkg::RESET_FACTOR_LEVEL2;
            regs_reg.port_base_bits <= arl_pkg::RESET_PORT_BASE_BITS;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// File: design/arl_core.sv
// Accumulator and gain-level state with the per-sample update logic.
`timescale 1ns / 1ps
`include "autorange_light_averager_top_defines.svh"

module arl_core
#(
    parameter int unsigned AVG_SHIFT = 6,
    parameter int unsigned ACC_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [arl_pkg::SAMPLE_W-1:0]  adc_raw,
    input  arl_pkg::cfg_t                 regs,
    output arl_pkg::result_t              result
);

    localparam int unsigned SUM_W =
        ((ACC_WIDTH > arl_pkg::PROD_W) ? ACC_WIDTH : arl_pkg::PROD_W) + 1;
    localparam int unsigned OUT_W = arl_pkg::SUM_OUT_W;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    logic [ACC_WIDTH-1:0]         acc_reg;
    logic [ACC_WIDTH-1:0]         acc_next;
    logic [arl_pkg::LEVEL_W-1:0]  level_reg;
    logic [arl_pkg::LEVEL_W-1:0]  level_next;

    logic [arl_pkg::SAMPLE_W-1:0] inverted;
    logic [arl_pkg::FACTOR_W-1:0] factor;
    logic [arl_pkg::PROD_W-1:0]   product;
    logic [ACC_WIDTH-1:0]         decayed;
    logic [SUM_W-1:0]             sum;

    assign inverted = arl_pkg::SAMPLE_MAX - adc_raw;

    // The multiplier follows the level held before this sample's update.
    always_comb
    begin
        case (level_reg)
            arl_pkg::LEVEL_MIN: factor = regs.factor_level0;
            arl_pkg::LEVEL_MID: factor = regs.factor_level1;
            default:            factor = regs.factor_level2;
        endcase
    end

    assign product = arl_pkg::PROD_W'(inverted) * arl_pkg::PROD_W'(factor);
    assign decayed = acc_reg - (acc_reg >> AVG_SHIFT);
    assign sum     = SUM_W'(decayed) + SUM_W'(product);
    assign acc_next = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_WIDTH-1:0];

    // A step up wins when both thresholds are crossed.
    always_comb
    begin
        level_next = level_reg;
        if ((inverted > regs.high_threshold) && (level_reg < arl_pkg::LEVEL_MAX))
        begin
            level_next = level_reg + 2'd1;
        end
        else if ((inverted < regs.low_threshold) && (level_reg != arl_pkg::LEVEL_MIN))
        begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            level_reg <= arl_pkg::LEVEL_MIN;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            level_reg <= level_next;
        end
    end

    assign result.brightness_sum = OUT_W'(acc_next);
    assign result.gain_level     = level_next;
    assign result.port_mode      = arl_pkg::drive_code(level_next) | regs.port_base_bits;

    `ARL_ASSERT(level_in_range, clk, rst_n, level_reg != arl_pkg::LEVEL_UNUSED, "gain level reached the unused code")
    `ARL_ASSERT(level_single_step, clk, rst_n, advance |-> ((level_next == level_reg) || (level_next == level_reg + 2'd1) || (level_next == level_reg - 2'd1)), "gain level moved by more than one step")
    `ARL_ASSERT_NEXT(acc_holds_when_idle, clk, rst_n, !advance, $stable(acc_reg), "accumulator changed without a sample")

endmodule

// File: design/autorange_light_averager_top.sv
// Top level of the auto-ranging light averager: channels, pipeline and state.
`timescale 1ns / 1ps
`include "autorange_light_averager_top_defines.svh"

// Auto-ranging light averager. Each request on the sample channel carries one
// raw converter byte; the block inverts it, decays the moving-average
// accumulator by one 2^AVG_SHIFT-th, adds the inverted sample times the
// current gain level's factor with saturation, steps the gain level by at most
// one against the two thresholds, and returns one result request with the new
// accumulator, gain level and port drive byte. A new sample is taken every
// clock cycle unless result backpressure holds it off. An accepted sample sits
// in the input register until the result register is free or drained; then
// the accumulate and level update runs into the result register, which
// presents the result. The accumulator and level are updated as each sample
// moves into the result register, so back-to-back samples see each other's
// updates. Backpressure on the result channel stalls the input one stage back.
// Configuration writes are taken at any time and should only be issued while
// no sample is in flight.
module autorange_light_averager_top
#(
    parameter int unsigned AVG_SHIFT = 6,
    parameter int unsigned ACC_WIDTH = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    arl_in_if.sink     sample,
    arl_out_if.source  result,
    arl_cfg_if.sink    cfg
);

    arl_pkg::cfg_t                regs;
    arl_pkg::result_t             core_result;
    arl_pkg::result_t             out_data_reg;

    logic                         stage_valid_reg;
    logic                         stage_valid_next;
    logic [arl_pkg::SAMPLE_W-1:0] stage_raw_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         advance;
    logic                         sample_accept;

    arl_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    arl_core
    #(
        .AVG_SHIFT (AVG_SHIFT),
        .ACC_WIDTH (ACC_WIDTH)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .adc_raw (stage_raw_reg),
        .regs    (regs),
        .result  (core_result)
    );

    // The staged sample moves on whenever the result register is free or drained.
    assign advance       = stage_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready  = !stage_valid_reg || advance;
    assign sample_accept = sample.valid && sample.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (sample_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            stage_raw_reg <= sample.adc_raw;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.brightness_sum = out_data_reg.brightness_sum;
    assign result.gain_level     = out_data_reg.gain_level;
    assign result.port_mode      = out_data_reg.port_mode;

    `ARL_ASSERT_NEXT(accept_fills_stage, clk, rst_n, sample_accept, stage_valid_reg, "accepted sample did not reach the input register")
    `ARL_ASSERT_NEXT(stage_drains_to_output, clk, rst_n, stage_valid_reg && !out_valid_reg, out_valid_reg, "staged sample did not move into an empty result register")
    `ARL_ASSERT_NEXT(taken_result_clears, clk, rst_n, out_valid_reg && result.ready && !stage_valid_reg, !out_valid_reg, "taken result was delivered again")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the auto-ranging light averager top level.
`timescale 1ns / 1ps

module testbench;
    import arl_pkg::*;

    localparam int unsigned AVG_SHIFT       = 6;
    localparam int unsigned ACC_WIDTH       = 24;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 64;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned END_WAIT        = 8;

    localparam logic [ACC_WIDTH-1:0] ACC_CEILING = '1;

    // The index field can address two slots past the register list.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    arl_in_if  sample_ch ();
    arl_out_if result_ch ();
    arl_cfg_if cfg_ch ();

    autorange_light_averager_top #(
        .AVG_SHIFT (AVG_SHIFT),
        .ACC_WIDTH (ACC_WIDTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #4 clk = ~clk;

    // Predicted state of the block.
    cfg_t                 model_cfg;
    logic [ACC_WIDTH-1:0] model_acc;
    logic [LEVEL_W-1:0]   model_level;

    result_t     expected_readings[$];
    int unsigned failures = 0;
    bit          handshake_seen = 1'b0;
    bit          idling = 1'b1;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_LOW_THRESHOLD:  model_cfg.low_threshold  = value[THRESH_W-1:0];
            REG_HIGH_THRESHOLD: model_cfg.high_threshold = value[THRESH_W-1:0];
            REG_FACTOR_LEVEL0:  model_cfg.factor_level0  = value[FACTOR_W-1:0];
            REG_FACTOR_LEVEL1:  model_cfg.factor_level1  = value[FACTOR_W-1:0];
            REG_FACTOR_LEVEL2:  model_cfg.factor_level2  = value[FACTOR_W-1:0];
            REG_PORT_BASE_BITS: model_cfg.port_base_bits = value[BASE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic result_t step_averager(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0]  dark;
        logic [FACTOR_W-1:0]  factor;
        logic [ACC_WIDTH+1:0] sum;
        logic [LEVEL_W-1:0]   lv;
        result_t              r;
        dark = SAMPLE_MAX - raw;
        lv = model_level;
        case (lv)
            LEVEL_MIN: factor = model_cfg.factor_level0;
            LEVEL_MID: factor = model_cfg.factor_level1;
            default:   factor = model_cfg.factor_level2;
        endcase
        sum = model_acc - (model_acc >> AVG_SHIFT) + dark * factor;
        if (sum > ACC_CEILING)
            sum = ACC_CEILING;
        model_acc = sum[ACC_WIDTH-1:0];
        // The step up is tried first; the step down only when no step up happens.
        if (dark > model_cfg.high_threshold && lv < LEVEL_MAX)
            lv = lv + 1'b1;
        else if (dark < model_cfg.low_threshold && lv > LEVEL_MIN)
            lv = lv - 1'b1;
        model_level = lv;
        r.brightness_sum = model_acc[SUM_OUT_W-1:0];
        r.gain_level = lv;
        case (lv)
            LEVEL_MIN: r.port_mode = DRIVE_LEVEL0 | model_cfg.port_base_bits;
            LEVEL_MID: r.port_mode = DRIVE_LEVEL1 | model_cfg.port_base_bits;
            default:   r.port_mode = DRIVE_LEVEL2 | model_cfg.port_base_bits;
        endcase
        return r;
    endfunction

    function automatic void check_reading();
        result_t want;
        if (expected_readings.size() == 0)
        begin
            if (failures < REPORT_LIMIT)
                $display("%0t: unexpected result sum=%0d level=%0d port=%02h", $realtime,
                         result_ch.brightness_sum, result_ch.gain_level, result_ch.port_mode);
            failures++;
            return;
        end
        want = expected_readings.pop_front();
        if (want.brightness_sum !== result_ch.brightness_sum
            || want.gain_level !== result_ch.gain_level
            || want.port_mode !== result_ch.port_mode)
        begin
            if (failures < REPORT_LIMIT)
                $display("%0t: mismatch sum %0d/%0d level %0d/%0d port %02h/%02h (exp/act)",
                         $realtime, want.brightness_sum, result_ch.brightness_sum,
                         want.gain_level, result_ch.gain_level,
                         want.port_mode, result_ch.port_mode);
            failures++;
        end
    endfunction

    // Inputs and outputs only move at the rising edge, so the values seen at the
    // falling edge are the ones the next rising edge will act on.
    always @(negedge clk)
    begin
        handshake_seen = 1'b0;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                apply_register(cfg_ch.index, cfg_ch.data);
                handshake_seen = 1'b1;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                expected_readings.push_back(step_averager(sample_ch.adc_raw));
                handshake_seen = 1'b1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                check_reading();
                handshake_seen = 1'b1;
            end
        end
    end

    initial
    begin : receiver
        int unsigned burst;
        int unsigned hold_left;
        burst = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ack != hold_req)
            begin
                hold_ack = hold_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (burst != 0)
            begin
                burst--;
                result_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 4) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || handshake_seen)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL autorange_light_averager_top");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
        bit taken;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.adc_raw <= raw;
        do
        begin
            @(negedge clk);
            taken = sample_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        bit taken;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Always waits for a rising edge first, so a request line lowered just before
    // is never raised again in the same step.
    task automatic wait_drain();
        do
            @(posedge clk);
        while (expected_readings.size() != 0);
    endtask

    // Unused upper data bits of the 8-bit registers get random values; the
    // block must drop them.
    task automatic load_config(input cfg_t c);
        write_register(REG_LOW_THRESHOLD, {2'($urandom), c.low_threshold});
        write_register(REG_HIGH_THRESHOLD, {2'($urandom), c.high_threshold});
        write_register(REG_FACTOR_LEVEL0, c.factor_level0);
        write_register(REG_FACTOR_LEVEL1, c.factor_level1);
        write_register(REG_FACTOR_LEVEL2, c.factor_level2);
        write_register(REG_PORT_BASE_BITS, {2'($urandom), c.port_base_bits});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.low_threshold  = $urandom_range(0, 120);
        c.high_threshold = $urandom_range(100, 255);
        c.factor_level0  = $urandom;
        c.factor_level1  = $urandom;
        c.factor_level2  = $urandom;
        c.port_base_bits = $urandom;
        return c;
    endfunction

    // Mix of uniform samples, both ends of the range, and samples whose
    // inverse sits at or one step beside one of the thresholds.
    function automatic logic [SAMPLE_W-1:0] pick_raw();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 15);
            2: v = $urandom_range(240, 255);
            default:
            begin
                v = 255 - ($urandom_range(0, 1) ? model_cfg.high_threshold
                                                : model_cfg.low_threshold);
                v = v + $urandom_range(0, 2) - 1;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_random(input int unsigned count);
        repeat (count) send_sample(pick_raw());
    endtask

    task automatic test_reset_values();
        logic [SAMPLE_W-1:0] raws[] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                                        8'd55, 8'd54, 8'd54, 8'd240, 8'd241, 8'hAA, 8'h55};
        foreach (raws[i])
            send_sample(raws[i]);
        sample_ch.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic test_gain_steps();
        cfg_t c;
        // Both thresholds met by the first three samples: up wins until level two blocks it; the last one steps down.
        c = '{low_threshold: 8'd255, high_threshold: 8'd0, factor_level0: 10'h3FF,
              factor_level1: 10'h3FF, factor_level2: 10'h3FF, port_base_bits: 8'hFF};
        load_config(c);
        send_sample(8'd100);
        send_sample(8'd100);
        send_sample(8'd100);
        send_sample(8'hFF);
        sample_ch.valid <= 1'b0;
        wait_drain();
        write_register(REG_UNMAPPED_LO, 10'h3FF);
        write_register(REG_UNMAPPED_HI, 10'h155);
        write_register(REG_LOW_THRESHOLD, 10'h300);
        write_register(REG_HIGH_THRESHOLD, 10'h0FF);
        write_register(REG_FACTOR_LEVEL0, 10'h000);
        write_register(REG_PORT_BASE_BITS, 10'h21F);
        cfg_ch.valid <= 1'b0;
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'h80);
        sample_ch.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic test_random_settings();
        cfg_t c;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: c = '{low_threshold: 8'hFF, high_threshold: 8'hFF, factor_level0: 10'h3FF,
                         factor_level1: 10'h3FF, factor_level2: 10'h3FF,
                         port_base_bits: 8'hFF};
                2: c = '{low_threshold: 8'h00, high_threshold: 8'h00, factor_level0: 10'h000,
                         factor_level1: 10'h000, factor_level2: 10'h000,
                         port_base_bits: 8'h00};
                default: c = random_config();
            endcase
            load_config(c);
            send_random(60);
            sample_ch.valid <= 1'b0;
            wait_drain();
        end
    endtask

    task automatic test_accumulator_ceiling();
        cfg_t c;
        // With a 1/64 decay the sum settles just under the ceiling, so near-zero raw
        // input at the largest factor drives it as close as the arithmetic allows.
        c = '{low_threshold: 8'h00, high_threshold: 8'd100, factor_level0: 10'h3FF,
              factor_level1: 10'h3FF, factor_level2: 10'h3FF, port_base_bits: 8'h0F};
        load_config(c);
        repeat (150) send_sample($urandom_range(0, 3));
        sample_ch.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        load_config(random_config());
        hold_req++;
        send_random(30);
        sample_ch.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic test_input_pause();
        send_random(15);
        sample_ch.valid <= 1'b0;
        wait_drain();
        send_random(15);
        sample_ch.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic test_steady_stream();
        idling = 1'b0;
        load_config(random_config());
        send_random(40);
        sample_ch.valid <= 1'b0;
        wait_drain();
    endtask

    initial
    begin
        model_cfg = '{low_threshold: RESET_LOW_THRESHOLD,
                      high_threshold: RESET_HIGH_THRESHOLD,
                      factor_level0: RESET_FACTOR_LEVEL0,
                      factor_level1: RESET_FACTOR_LEVEL1,
                      factor_level2: RESET_FACTOR_LEVEL2,
                      port_base_bits: RESET_PORT_BASE_BITS};
        model_acc = '0;
        model_level = LEVEL_MIN;
        sample_ch.valid   <= 1'b0;
        sample_ch.adc_raw <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_gain_steps();
        test_random_settings();
        test_accumulator_ceiling();
        test_output_backpressure();
        test_input_pause();
        test_steady_stream();

        repeat (END_WAIT) @(posedge clk);
        if (failures == 0 && expected_readings.size() == 0)
            $display("PASS autorange_light_averager_top");
        else
            $display("FAIL autorange_light_averager_top");
        $finish;
    end

endmodule
